// File: rtl/parking_sensor_mode_and_beeper_macros.svh
// assertion macros for the parking sensor block
`ifndef PARKING_SENSOR_MODE_AND_BEEPER_MACROS_SVH
`define PARKING_SENSOR_MODE_AND_BEEPER_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define PSMB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition this cycle implies consequence next cycle
`define PSMB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PSMB_ASSERT(lbl, clk, rst, prop, msg)

`define PSMB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/psmb_pkg.sv
package psmb_pkg;

   typedef enum logic {
      OP_TICK    = 1'b0,
      OP_MEASURE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MODE_SLOW   = 2'd0,
      MODE_MEDIUM = 2'd1,
      MODE_FAST   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_TRIGGER_COUNT = 2'd0,
      CSR_FAST_TIMEOUT  = 2'd1,
      CSR_FAST_INTERVAL = 2'd2,
      CSR_SLOW_INTERVAL = 2'd3
   } csr_idx_type;

   localparam int unsigned DIST_W  = 9;
   localparam int unsigned CD_W    = 10;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned MS_W    = 16;
   localparam int unsigned WAIT_W  = 17;

   localparam logic [CD_W-1:0]   BEEP_MS    = 10'd20;
   localparam logic [CD_W-1:0]   RECHECK_MS = 10'd50;
   localparam logic [DIST_W-1:0] FAR_CM     = 9'd200;
   localparam logic [DIST_W-1:0] PARK_DIST_RESET = 9'd150;

   localparam logic [COUNT_W-1:0] TRIGGER_COUNT_RESET = 8'd3;
   localparam logic [MS_W-1:0]    FAST_TIMEOUT_RESET  = 16'd10000;
   localparam logic [MS_W-1:0]    FAST_INTERVAL_RESET = 16'd100;
   localparam logic [MS_W-1:0]    SLOW_INTERVAL_RESET = 16'd1000;

   typedef struct packed {
      op_type              opcode;
      logic [DIST_W-1:0]   dist_first;
      logic [DIST_W-1:0]   dist_second;
      logic [DIST_W-1:0]   dist_third;
      logic                ok_first;
      logic                ok_second;
      logic                ok_third;
   } req_type;

   typedef struct packed {
      logic                buzzer_level;
      logic                park_active;
      mode_type            mode;
      logic [DIST_W-1:0]   avg_distance;
      logic [WAIT_W-1:0]   wait_ms;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  trigger_count;
      logic [MS_W-1:0]     fast_timeout_ms;
      logic [MS_W-1:0]     fast_interval_ms;
      logic [MS_W-1:0]     slow_interval_ms;
   } cfg_type;

   // silent gap after a beep, zero means too far to beep
   function automatic logic [CD_W-1:0] silence_for(input logic [DIST_W-1:0] cm);
      logic [CD_W-1:0] gap;
      if (cm >= FAR_CM)       gap = 10'd0;
      else if (cm > 9'd120)   gap = 10'd800;
      else if (cm > 9'd90)    gap = 10'd500;
      else if (cm > 9'd70)    gap = 10'd400;
      else if (cm > 9'd50)    gap = 10'd300;
      else if (cm > 9'd30)    gap = 10'd200;
      else if (cm > 9'd20)    gap = 10'd120;
      else if (cm > 9'd12)    gap = 10'd60;
      else                    gap = 10'd25;
      return gap;
   endfunction

endpackage

// File: rtl/psmb_csr.sv
module psmb_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  psmb_pkg::csr_idx_type     csr_index,
   input  logic [15:0]               csr_data,
   output psmb_pkg::cfg_type         cfg
);
   import psmb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRIGGER_COUNT: cfg_in.trigger_count    = csr_data[COUNT_W-1:0];
            CSR_FAST_TIMEOUT:  cfg_in.fast_timeout_ms  = csr_data[MS_W-1:0];
            CSR_FAST_INTERVAL: cfg_in.fast_interval_ms = csr_data[MS_W-1:0];
            CSR_SLOW_INTERVAL: cfg_in.slow_interval_ms = csr_data[MS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_count    <= TRIGGER_COUNT_RESET;
         cfg_ff.fast_timeout_ms  <= FAST_TIMEOUT_RESET;
         cfg_ff.fast_interval_ms <= FAST_INTERVAL_RESET;
         cfg_ff.slow_interval_ms <= SLOW_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/psmb_core.sv
`include "parking_sensor_mode_and_beeper_macros.svh"

module psmb_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  psmb_pkg::req_type   item,
   input  psmb_pkg::cfg_type   cfg,
   output psmb_pkg::rsp_type   result
);
   import psmb_pkg::*;

   // multiply by 683 and drop 11 bits: exact divide by 3 below 2048
   localparam logic [20:0] DIV3_MUL   = 21'd683;
   localparam int unsigned DIV3_SHIFT = 11;

   logic                beep_on_ff,   beep_on_in;
   logic [CD_W-1:0]     beep_cd_ff,   beep_cd_in;
   logic                park_en_ff,   park_en_in;
   logic [DIST_W-1:0]   park_dist_ff, park_dist_in;
   logic [COUNT_W-1:0]  succ_ff,      succ_in;
   logic                medium_ff,    medium_in;
   logic                fast_ff,      fast_in;
   logic [MS_W-1:0]     elapsed_ff,   elapsed_in;

   logic [10:0]         dist_sum;
   logic [20:0]         div_prod;
   logic [DIST_W-1:0]   avg;
   logic                all_ok;
   logic [CD_W-1:0]     cd_dec;
   logic [CD_W-1:0]     gap;
   logic [COUNT_W-1:0]  succ_next;

   assign dist_sum = 11'(item.dist_first) + 11'(item.dist_second) + 11'(item.dist_third);
   assign div_prod = 21'(dist_sum) * DIV3_MUL;
   assign avg      = div_prod[DIV3_SHIFT +: DIST_W];
   assign all_ok   = item.ok_first && item.ok_second && item.ok_third;
   assign cd_dec   = (beep_cd_ff != '0) ? beep_cd_ff - 10'd1 : beep_cd_ff;
   assign gap      = silence_for(park_dist_ff);
   assign succ_next = (succ_ff != '1) ? succ_ff + 8'd1 : succ_ff;

   always_comb begin
      beep_on_in   = beep_on_ff;
      beep_cd_in   = beep_cd_ff;
      park_en_in   = park_en_ff;
      park_dist_in = park_dist_ff;
      succ_in      = succ_ff;
      medium_in    = medium_ff;
      fast_in      = fast_ff;
      elapsed_in   = elapsed_ff;
      if (fire) begin
         if (item.opcode == OP_TICK) begin
            if (fast_ff && (elapsed_ff != '1)) begin
               elapsed_in = elapsed_ff + 16'd1;
            end
            beep_cd_in = cd_dec;
            if (!park_en_ff) begin
               beep_on_in = 1'b0;
            end else if (cd_dec == '0) begin
               if (gap == '0) begin
                  beep_on_in = 1'b0;
                  beep_cd_in = RECHECK_MS;
               end else if (beep_on_ff) begin
                  beep_on_in = 1'b0;
                  beep_cd_in = gap;
               end else begin
                  beep_on_in = 1'b1;
                  beep_cd_in = BEEP_MS;
               end
            end
         end else begin
            if (all_ok) begin
               medium_in    = 1'b1;
               park_dist_in = avg;
               succ_in      = succ_next;
               if (!fast_ff && (succ_next >= cfg.trigger_count)) begin
                  medium_in  = 1'b0;
                  fast_in    = 1'b1;
                  park_en_in = 1'b1;
                  elapsed_in = '0;
               end else if (fast_ff) begin
                  elapsed_in = '0;
               end
            end else begin
               succ_in   = '0;
               medium_in = 1'b0;
            end
            // timeout is judged after the success handling
            if (fast_in && (elapsed_in >= cfg.fast_timeout_ms)) begin
               fast_in    = 1'b0;
               succ_in    = '0;
               park_en_in = 1'b0;
               beep_on_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      result.buzzer_level = beep_on_in;
      result.park_active  = park_en_in;
      result.avg_distance = park_dist_in;
      if (fast_in) begin
         result.mode    = MODE_FAST;
         result.wait_ms = WAIT_W'(cfg.fast_interval_ms);
      end else if (medium_in) begin
         result.mode    = MODE_MEDIUM;
         result.wait_ms = {cfg.fast_interval_ms, 1'b0};
      end else begin
         result.mode    = MODE_SLOW;
         result.wait_ms = WAIT_W'(cfg.slow_interval_ms);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beep_on_ff   <= 1'b0;
         beep_cd_ff   <= '0;
         park_en_ff   <= 1'b0;
         park_dist_ff <= PARK_DIST_RESET;
         succ_ff      <= '0;
         medium_ff    <= 1'b0;
         fast_ff      <= 1'b0;
         elapsed_ff   <= '0;
      end else begin
         beep_on_ff   <= beep_on_in;
         beep_cd_ff   <= beep_cd_in;
         park_en_ff   <= park_en_in;
         park_dist_ff <= park_dist_in;
         succ_ff      <= succ_in;
         medium_ff    <= medium_in;
         fast_ff      <= fast_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   `PSMB_ASSERT(a_park_tracks_fast, clock, reset, park_en_ff == fast_ff, "park beeping out of step with fast mode")
   `PSMB_ASSERT(a_beep_needs_park, clock, reset, !beep_on_ff || park_en_ff, "buzzer on while park beeping disabled")
   `PSMB_ASSERT(a_countdown_range, clock, reset, beep_cd_ff <= 10'd800, "beep countdown beyond longest gap")

endmodule

// File: rtl/parking_sensor_mode_and_beeper.sv
// parking sensor mode control and park beeper
// a taken request beat is offered on rsp once it has moved into a free result slot
// throughput: one beat per cycle while the result slot is free, set by the
//   single-pass update between the input register and the result register
// reset: synchronous active-high, clears both stages and all mode state, loads
//   register defaults (trigger 3, timeout 10000, fast 100, slow 1000)
`include "parking_sensor_mode_and_beeper_macros.svh"

module parking_sensor_mode_and_beeper (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  psmb_pkg::req_type       req_data,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output psmb_pkg::rsp_type       rsp_data,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  psmb_pkg::csr_idx_type   csr_index,
   input  logic [15:0]             csr_data
);
   import psmb_pkg::*;

   // input stage holds one request beat
   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff,  in_data_in;

   // result stage, kept apart from the input so a waiting beat does not block intake
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_data_ff,  out_data_in;

   logic     out_free;
   logic     fire;
   logic     req_take;
   cfg_type  cfg;
   rsp_type  core_result;

   // result slot free when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // the held request moves through the update logic into the result slot
   assign fire      = in_valid_ff && out_free;
   // only back-pressure when the held beat cannot move on
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   psmb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   psmb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         out_data_in  = core_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `PSMB_ASSERT(a_stall_needs_item, clock, reset, !req_stall || in_valid_ff, "stall with no held beat")
   `PSMB_ASSERT_NEXT(a_fire_gives_result, clock, reset, fire, out_valid_ff, "processed beat lost")
   `PSMB_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result beat changed")

endmodule

// File: test/park_beeper_checker.sv
`timescale 1ns / 100ps

module park_beeper_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  psmb_pkg::req_type       req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  psmb_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  psmb_pkg::csr_idx_type   csr_index,
   input  logic [15:0]             csr_data,
   output int                      mismatches,
   output int                      owed
);

   import psmb_pkg::*;

   // register copies
   logic [COUNT_W-1:0] trig_need;
   logic [MS_W-1:0]    fast_limit;
   logic [MS_W-1:0]    fast_wait;
   logic [MS_W-1:0]    slow_wait;

   // mode and beeper state
   logic               beep_sounding;
   logic [CD_W-1:0]    beep_timer;
   logic               beeper_armed;
   logic [DIST_W-1:0]  stored_cm;
   logic [COUNT_W-1:0] good_rounds;
   logic               medium_on;
   logic               fast_on;
   logic [MS_W-1:0]    fast_age;

   rsp_type            due_indications [$];
   int                 error_total = 0;
   int                 owed_total = 0;

   assign mismatches = error_total;
   assign owed       = owed_total;

   function automatic logic [CD_W-1:0] quiet_gap(input logic [DIST_W-1:0] cm);
      logic [CD_W-1:0] g;
      g = 10'd25;
      if (cm > 9'd12)  g = 10'd60;
      if (cm > 9'd20)  g = 10'd120;
      if (cm > 9'd30)  g = 10'd200;
      if (cm > 9'd50)  g = 10'd300;
      if (cm > 9'd70)  g = 10'd400;
      if (cm > 9'd90)  g = 10'd500;
      if (cm > 9'd120) g = 10'd800;
      if (cm >= FAR_CM) g = 10'd0;
      return g;
   endfunction

   task automatic update_indication(input req_type r, output rsp_type ind);
      logic [10:0]     sum;
      logic [10:0]     avg;
      logic [CD_W-1:0] gap;
      if (r.opcode == OP_TICK) begin
         if (fast_on && fast_age != 16'hFFFF) fast_age = fast_age + 16'd1;
         if (beep_timer != '0) beep_timer = beep_timer - 10'd1;
         if (!beeper_armed) begin
            beep_sounding = 1'b0;
         end else if (beep_timer == '0) begin
            gap = quiet_gap(stored_cm);
            if (gap == '0) begin
               beep_sounding = 1'b0;
               beep_timer    = RECHECK_MS;
            end else if (beep_sounding) begin
               beep_sounding = 1'b0;
               beep_timer    = gap;
            end else begin
               beep_sounding = 1'b1;
               beep_timer    = BEEP_MS;
            end
         end
      end else begin
         if (r.ok_first && r.ok_second && r.ok_third) begin
            sum = {2'b00, r.dist_first} + {2'b00, r.dist_second} + {2'b00, r.dist_third};
            avg = sum / 11'd3;
            medium_on = 1'b1;
            stored_cm = avg[DIST_W-1:0];
            if (good_rounds != 8'hFF) good_rounds = good_rounds + 8'd1;
            if (!fast_on && good_rounds >= trig_need) begin
               medium_on    = 1'b0;
               fast_on      = 1'b1;
               beeper_armed = 1'b1;
               fast_age     = '0;
            end else if (fast_on) begin
               fast_age = '0;
            end
         end else begin
            good_rounds = '0;
            medium_on   = 1'b0;
         end
         if (fast_on && fast_age >= fast_limit) begin
            fast_on       = 1'b0;
            good_rounds   = '0;
            beeper_armed  = 1'b0;
            beep_sounding = 1'b0;
         end
      end
      ind.buzzer_level = beep_sounding;
      ind.park_active  = beeper_armed;
      ind.avg_distance = stored_cm;
      if (fast_on) begin
         ind.mode    = MODE_FAST;
         ind.wait_ms = {1'b0, fast_wait};
      end else if (medium_on) begin
         ind.mode    = MODE_MEDIUM;
         ind.wait_ms = {fast_wait, 1'b0};
      end else begin
         ind.mode    = MODE_SLOW;
         ind.wait_ms = {1'b0, slow_wait};
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         trig_need     = TRIGGER_COUNT_RESET;
         fast_limit    = FAST_TIMEOUT_RESET;
         fast_wait     = FAST_INTERVAL_RESET;
         slow_wait     = SLOW_INTERVAL_RESET;
         beep_sounding = 1'b0;
         beep_timer    = '0;
         beeper_armed  = 1'b0;
         stored_cm     = PARK_DIST_RESET;
         good_rounds   = '0;
         medium_on     = 1'b0;
         fast_on       = 1'b0;
         fast_age      = '0;
         due_indications.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TRIGGER_COUNT: trig_need  = csr_data[COUNT_W-1:0];
               CSR_FAST_TIMEOUT:  fast_limit = csr_data;
               CSR_FAST_INTERVAL: fast_wait  = csr_data;
               CSR_SLOW_INTERVAL: slow_wait  = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_indications.size() == 0) begin
               $error("result beat with nothing predicted");
               error_total++;
            end else begin
               want = due_indications.pop_front();
               check_field("buzzer_level", want.buzzer_level, rsp_data.buzzer_level);
               check_field("park_active", want.park_active, rsp_data.park_active);
               check_field("mode", want.mode, rsp_data.mode);
               check_field("avg_distance", want.avg_distance, rsp_data.avg_distance);
               check_field("wait_ms", want.wait_ms, rsp_data.wait_ms);
            end
         end
         if (req_valid && !req_stall) begin
            update_indication(req_data, fresh);
            due_indications.push_back(fresh);
         end
      end
      owed_total = due_indications.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

   import psmb_pkg::*;

   // cycles without any beat on any channel before the run is given up
   localparam int QUIET_LIMIT = 2000;

   // distances that sit on either side of the beeper's band edges
   localparam int unsigned LANDMARKS [18] = '{0, 12, 13, 20, 21, 30, 31, 50, 51,
                                              70, 71, 90, 91, 120, 121, 199, 200, 511};

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = CSR_TRIGGER_COUNT;
   logic [15:0] csr_data  = '0;

   int          mismatches;
   int          owed;
   int          quiet_cycles = 0;

   // sender burst bookkeeping
   int          burst_left = 0;
   bit          gaps_on    = 1'b1;

   // receiver stall pattern
   int          stall_mode = 0;
   int          stall_left = 0;

   always #5 clock = ~clock;

   parking_sensor_mode_and_beeper i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   park_beeper_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .owed       (owed)
   );

   // receiver: stretches of free flow, light, heavy and near-total stalling
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= 0;
         stall_left <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(5, 200);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // watchdog: any beat on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $error("no beat for %0d cycles, %0d results still owed", QUIET_LIMIT, owed);
      $display("tb: failure");
      $finish;
   end

   // a measurement round with the given readings and ok flags (first, second, third)
   function automatic req_type measure_beat(input logic [8:0] a, input logic [8:0] b,
                                            input logic [8:0] c, input logic [2:0] oks);
      req_type r;
      r.opcode      = OP_MEASURE;
      r.dist_first  = a;
      r.dist_second = b;
      r.dist_third  = c;
      {r.ok_first, r.ok_second, r.ok_third} = oks;
      return r;
   endfunction

   // random beat: tick_pct percent ticks, ok_pct percent of rounds fully good
   function automatic req_type random_beat(input int tick_pct, input int ok_pct);
      req_type r;
      int      base;
      r.opcode = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_MEASURE;
      case ($urandom_range(0, 9))
         0: begin
            // full range, every bit of every reading moves
            r.dist_first  = 9'($urandom_range(0, 511));
            r.dist_second = 9'($urandom_range(0, 511));
            r.dist_third  = 9'($urandom_range(0, 511));
         end
         1: begin
            base = LANDMARKS[$urandom_range(0, 17)];
            r.dist_first  = 9'(base);
            r.dist_second = 9'(base);
            r.dist_third  = 9'(base);
         end
         default: begin
            // three readings of one obstacle, each at most six above a shared base
            base = $urandom_range(0, 230);
            r.dist_first  = 9'(base + $urandom_range(0, 6));
            r.dist_second = 9'(base + $urandom_range(0, 6));
            r.dist_third  = 9'(base + $urandom_range(0, 6));
         end
      endcase
      if ($urandom_range(0, 99) < ok_pct) begin
         {r.ok_first, r.ok_second, r.ok_third} = 3'b111;
      end else begin
         // at least one reading failed
         {r.ok_first, r.ok_second, r.ok_third} = 3'($urandom_range(0, 6));
      end
      return r;
   endfunction

   // offer one beat; bursts of random length, with random gaps between them while gaps_on is set
   task automatic send_beat(input req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (gaps_on) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // hold the sender until every owed result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed != 0);
   endtask

   // write all four registers, block idle; trigger's upper byte carries junk
   task automatic program_regs(input logic [7:0] trig, input logic [15:0] tmo,
                               input logic [15:0] fst, input logic [15:0] slw);
      csr_idx_type idx;
      logic [15:0] val;
      for (int i = 0; i < 4; i++) begin
         idx = csr_idx_type'(i);
         case (idx)
            CSR_TRIGGER_COUNT: begin
               val      = 16'($urandom);
               val[7:0] = trig;
            end
            CSR_FAST_TIMEOUT:  val = tmo;
            CSR_FAST_INTERVAL: val = fst;
            default:           val = slw;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= val;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int tick_pct;
      int ok_pct;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset register values (trigger of three)
      send_beat(random_beat(100, 0));                       // tick with the beeper held off
      send_beat(measure_beat(9'd0, 9'd0, 9'd0, 3'b111));      // nearest average
      send_beat(measure_beat(9'd511, 9'd511, 9'd511, 3'b111)); // widest average
      send_beat(measure_beat(9'($urandom), 9'($urandom), 9'($urandom), 3'b011));
      send_beat(measure_beat(9'($urandom), 9'($urandom), 9'($urandom), 3'b101));
      send_beat(measure_beat(9'($urandom), 9'($urandom), 9'($urandom), 3'b110));
      send_beat(measure_beat(9'd2, 9'd2, 9'd1, 3'b111));      // average truncates down
      send_beat(measure_beat(9'd10, 9'd10, 9'd10, 3'b111));
      send_beat(measure_beat(9'd4, 9'd5, 9'd6, 3'b111));      // third success, fast mode
      repeat (5) send_beat(random_beat(100, 0));              // beeper starts sounding
      send_beat(measure_beat(9'd511, 9'd510, 9'd509, 3'b111)); // medium set while fast
      send_beat(measure_beat(9'd300, 9'd300, 9'd300, 3'b000)); // failure in fast mode
      repeat (4) send_beat(random_beat(100, 0));              // far away, recheck only
      send_beat(measure_beat(9'd13, 9'd12, 9'd14, 3'b111));

      // lowest settings: zero trigger, zero timeout ends fast mode on the same round
      drain_results();
      program_regs(8'd0, 16'd0, 16'd0, 16'd0);
      send_beat(measure_beat(9'd40, 9'd41, 9'd42, 3'b111));
      send_beat(random_beat(100, 0));
      send_beat(measure_beat(9'd40, 9'd41, 9'd42, 3'b001));
      for (int n = 0; n < 150; n++) send_beat(random_beat(60, 80));

      // highest settings: 255 successes to reach fast mode, then a tick run and a
      // failed round well inside the longest timeout
      drain_results();
      program_regs(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int n = 0; n < 260; n++) send_beat(random_beat(0, 100));
      gaps_on = 1'b0;
      for (int n = 0; n < 100; n++) send_beat(random_beat(100, 0));
      gaps_on = 1'b1;
      send_beat(measure_beat(9'd60, 9'd60, 9'd60, 3'b110));
      for (int n = 0; n < 20; n++) send_beat(random_beat(70, 90));

      // random settings, mixed traffic; each phase pauses once mid-way
      for (int p = 0; p < 8; p++) begin
         drain_results();
         program_regs(8'($urandom_range(1, 6)),
                      (p % 2 == 0) ? 16'($urandom_range(10, 400))
                                   : 16'($urandom_range(400, 3000)),
                      16'($urandom), 16'($urandom));
         tick_pct = $urandom_range(50, 97);
         ok_pct   = $urandom_range(70, 95);
         for (int n = 0; n < 150; n++) begin
            if (n == 75) drain_results();
            send_beat(random_beat(tick_pct, ok_pct));
         end
      end

      // wind down: everything owed back, then a few cycles for stray beats
      drain_results();
      repeat (5) @(posedge clock);
      if (owed != 0) $error("%0d results never arrived", owed);
      if (mismatches == 0 && owed == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/psmb_pkg.sv
rtl/psmb_csr.sv
rtl/psmb_core.sv
rtl/parking_sensor_mode_and_beeper.sv
test/park_beeper_checker.sv
test/tb.sv
